>>> design/assert_macros.svh
// Assertion macros used by the checker file of the sprite quad block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sqvt_pkg.sv
// Types, constants and tables shared by the sprite quad vertex transform.
`default_nettype none

package sqvt_pkg;

  // Trig resolution and CORDIC depth
  localparam int ANGLE_BITS  = 16;
  localparam int TRIG_STAGES = 16;

  // CORDIC datapath widths (Q2.30 vector, turn-scaled angle)
  localparam int XY_W   = 34;
  localparam int Z_W    = 33;
  localparam int TRIG_W = 17;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
  localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  // Corner, product and numerator widths
  localparam int SPAN_W = 18;
  localparam int PROD_W = SPAN_W + TRIG_W;
  localparam int SUM_W  = 36;
  localparam int OFF_W  = 32;
  localparam int DEN_W  = 16;
  localparam int DIV_Q_W = 16;
  localparam int DIV_STEPS = DIV_Q_W;
  localparam int TEX_W  = 17;
  localparam int SCR_W  = 13;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  // Saturated NDC codes
  localparam logic [15:0] NDC_MAX = 16'h7FFF;
  localparam logic [15:0] NDC_MIN = 16'h8000;

  // One corner on its way through the trig pipeline
  typedef struct packed {
    logic [1:0]               idx;
    logic signed [SPAN_W-1:0] lx;
    logic signed [SPAN_W-1:0] ly;
    logic signed [15:0]       px;
    logic signed [15:0]       py;
    logic [TEX_W-1:0]         tex_s;
    logic [TEX_W-1:0]         tex_t;
    logic                     last;
  } vtx_t;

  // Fields that ride along with the divider
  typedef struct packed {
    logic [1:0]       idx;
    logic [TEX_W-1:0] tex_s;
    logic [TEX_W-1:0] tex_t;
    logic             last;
  } side_t;

  // Range flags of the two quotients
  typedef struct packed {
    logic neg_x;
    logic hi_x;
    logic neg_y;
    logic hi_y;
  } sat_t;

  // atan(2^-i) in units of 2^32 per full turn
  function automatic logic [31:0] atan_turn(input int unsigned i);
    case (i)
      0:       return 32'd536870912;
      1:       return 32'd316933406;
      2:       return 32'd167458907;
      3:       return 32'd85004756;
      4:       return 32'd42667331;
      5:       return 32'd21354465;
      6:       return 32'd10679838;
      7:       return 32'd5340245;
      8:       return 32'd2670163;
      9:       return 32'd1335087;
      10:      return 32'd667544;
      11:      return 32'd333772;
      12:      return 32'd166886;
      13:      return 32'd83443;
      14:      return 32'd41722;
      15:      return 32'd20861;
      16:      return 32'd10430;
      17:      return 32'd5215;
      18:      return 32'd2608;
      19:      return 32'd1304;
      20:      return 32'd652;
      21:      return 32'd326;
      22:      return 32'd163;
      23:      return 32'd81;
      default: return 32'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> design/sprite_quad_vertex_transform_core.sv
// Top level: sprite in, four rotated, normalized and textured corner vertices out.
`default_nettype none

// Each accepted sprite yields four vertices, in the order (0,0), (0,h), (w,0), (w,h)
// relative to the pivot, one vertex per cycle while the output is not stalled; the
// corner sequencer at the input takes the next sprite as it issues the last corner
// of the current one. Each vertex passes a CORDIC stage per micro-rotation, then
// multiply, add, a range check and a 16-stage divider by eight times the screen
// size. The whole pipeline advances as one whenever the output register is empty
// or taken; a stall on the output holds every stage. Screen registers are read by
// sprites in flight, so write them only while the pipeline is empty; a value of 0
// acts as 1. No start-up pass.
module sprite_quad_vertex_transform_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sprite requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [15:0]                  pos_x_i,
  input  logic signed [15:0]                  pos_y_i,
  input  logic [15:0]                         sprite_width_i,
  input  logic [15:0]                         sprite_height_i,
  input  logic signed [15:0]                  origin_x_i,
  input  logic signed [15:0]                  origin_y_i,
  input  logic [15:0]                         angle_i,
  input  logic [15:0]                         tex_u_i,
  input  logic [15:0]                         tex_v_i,
  input  logic [15:0]                         tex_w_i,
  input  logic [15:0]                         tex_h_i,
  // vertex requests
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          vertex_index_o,
  output logic signed [15:0]                  ndc_x_o,
  output logic signed [15:0]                  ndc_y_o,
  output logic [16:0]                         tex_s_o,
  output logic [16:0]                         tex_t_o,
  output logic                                last_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sqvt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sqvt_pkg::SCR_W-1:0]          cfg_data_i
);
  import sqvt_pkg::*;

  localparam logic [SCR_W-1:0] RST_W = SCR_W'(1920);
  localparam logic [SCR_W-1:0] RST_H = SCR_W'(1080);
  localparam logic [OFF_W-1:0] RST_OFFX = (OFF_W'(RST_W) << 17) + (OFF_W'(RST_W) << 2);
  localparam logic [OFF_W-1:0] RST_OFFY = (OFF_W'(RST_H) << 17) - (OFF_W'(RST_H) << 2);

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [15:0]        sw;
    logic [15:0]        sh;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [15:0]        angle;
    logic [15:0]        u;
    logic [15:0]        v;
    logic [15:0]        tw;
    logic [15:0]        th;
  } sprite_t;

  logic adv;

  // ---------------------------------------------------------------------------
  // Configuration: screen size plus the offsets folded into the numerators
  // ---------------------------------------------------------------------------
  logic [SCR_W-1:0] scr_w_q, scr_h_q;
  logic [OFF_W-1:0] offx_q, offy_q;
  logic [SCR_W-1:0] cfg_eff;
  logic [OFF_W-1:0] offx_d, offy_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_eff = (cfg_data_i == '0) ? SCR_W'(1) : cfg_data_i;
    // offset = S * (4 + 8 * bias), bias 16384 for x and 16383 for y
    offx_d  = (OFF_W'(cfg_eff) << 17) + (OFF_W'(cfg_eff) << 2);
    offy_d  = (OFF_W'(cfg_eff) << 17) - (OFF_W'(cfg_eff) << 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= RST_W;
      scr_h_q <= RST_H;
      offx_q  <= RST_OFFX;
      offy_q  <= RST_OFFY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_SCREEN_WIDTH) begin
        scr_w_q <= cfg_eff;
        offx_q  <= offx_d;
      end else if (cfg_index_i == REG_SCREEN_HEIGHT) begin
        scr_h_q <= cfg_eff;
        offy_q  <= offy_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Corner sequencer: holds one sprite, issues its four corners
  // ---------------------------------------------------------------------------
  logic       ex_vld_q;
  logic [1:0] ex_cnt_q;
  sprite_t    spr_q;
  logic       take;
  vtx_t       corner;

  assign in_stall_o = ex_vld_q && !(adv && (ex_cnt_q == 2'd3));
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= 1'b0;
      ex_cnt_q <= '0;
    end else if (take) begin
      ex_vld_q <= 1'b1;
      ex_cnt_q <= '0;
    end else if (adv && ex_vld_q) begin
      ex_vld_q <= (ex_cnt_q != 2'd3);
      ex_cnt_q <= ex_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      spr_q <= '{px: pos_x_i, py: pos_y_i, sw: sprite_width_i, sh: sprite_height_i,
                 ox: origin_x_i, oy: origin_y_i, angle: angle_i, u: tex_u_i,
                 v: tex_v_i, tw: tex_w_i, th: tex_h_i};
    end
  end

  // Corner offsets from the pivot and texture coordinates
  always_comb begin
    corner.idx   = ex_cnt_q;
    corner.lx    = (ex_cnt_q[1] ? $signed({2'b0, spr_q.sw}) : '0)
                   - $signed({{2{spr_q.ox[15]}}, spr_q.ox});
    corner.ly    = (ex_cnt_q[0] ? $signed({2'b0, spr_q.sh}) : '0)
                   - $signed({{2{spr_q.oy[15]}}, spr_q.oy});
    corner.px    = spr_q.px;
    corner.py    = spr_q.py;
    corner.tex_s = {1'b0, spr_q.u} + (ex_cnt_q[1] ? {1'b0, spr_q.tw} : '0);
    corner.tex_t = {1'b0, spr_q.v} + (ex_cnt_q[0] ? {1'b0, spr_q.th} : '0);
    corner.last  = (ex_cnt_q == 2'd3);
  end

  // ---------------------------------------------------------------------------
  // Trig
  // ---------------------------------------------------------------------------
  logic                     cor_vld;
  logic signed [TRIG_W-1:0] cos_v, sin_v;
  vtx_t                     cor_side;

  sqvt_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (ex_vld_q),
    .angle_i (spr_q.angle),
    .side_i  (corner),
    .vld_o   (cor_vld),
    .cos_o   (cos_v),
    .sin_o   (sin_v),
    .side_o  (cor_side)
  );

  // ---------------------------------------------------------------------------
  // Rotation products and translated, biased positions
  // ---------------------------------------------------------------------------
  logic                     m_vld_q;
  logic signed [PROD_W-1:0] p_xc_q, p_ys_q, p_xs_q, p_yc_q;
  logic signed [SUM_W-1:0]  pxo_q, pyo_q;
  side_t                    m_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= cor_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_xc_q   <= cor_side.lx * cos_v;
      p_ys_q   <= cor_side.ly * sin_v;
      p_xs_q   <= cor_side.lx * sin_v;
      p_yc_q   <= cor_side.ly * cos_v;
      pxo_q    <= $signed({{(SUM_W-16){cor_side.px[15]}}, cor_side.px} << 14)
                  + $signed({{(SUM_W-OFF_W){1'b0}}, offx_q});
      pyo_q    <= $signed({{(SUM_W-16){cor_side.py[15]}}, cor_side.py} << 14)
                  + $signed({{(SUM_W-OFF_W){1'b0}}, offy_q});
      m_side_q <= '{idx: cor_side.idx, tex_s: cor_side.tex_s,
                    tex_t: cor_side.tex_t, last: cor_side.last};
    end
  end

  // ---------------------------------------------------------------------------
  // Numerators: rotated position plus bias
  // ---------------------------------------------------------------------------
  logic                    s_vld_q;
  logic signed [SUM_W-1:0] nx_q, ny_q;
  side_t                   s_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (adv) begin
      s_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q     <= SUM_W'(p_xc_q) - SUM_W'(p_ys_q) + pxo_q;
      ny_q     <= SUM_W'(p_xs_q) + SUM_W'(p_yc_q) + pyo_q;
      s_side_q <= m_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Division by eight times the screen size
  // ---------------------------------------------------------------------------
  logic               d_vld;
  logic [DIV_Q_W-1:0] qx, qy;
  sat_t               d_sat;
  side_t              d_side;

  sqvt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (s_vld_q),
    .num_x_i (nx_q),
    .num_y_i (ny_q),
    .den_x_i ({scr_w_q, 3'b0}),
    .den_y_i ({scr_h_q, 3'b0}),
    .side_i  (s_side_q),
    .vld_o   (d_vld),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .sat_o   (d_sat),
    .side_o  (d_side)
  );

  // ---------------------------------------------------------------------------
  // Output register: unbias, flip y, saturate
  // ---------------------------------------------------------------------------
  logic [15:0] ndc_x_d, ndc_y_d;

  always_comb begin
    if (d_sat.neg_x)     ndc_x_d = NDC_MIN;
    else if (d_sat.hi_x) ndc_x_d = NDC_MAX;
    else                 ndc_x_d = {~qx[15], qx[14:0]};
    if (d_sat.neg_y)     ndc_y_d = NDC_MAX;
    else if (d_sat.hi_y) ndc_y_d = NDC_MIN;
    else                 ndc_y_d = {qy[15], ~qy[14:0]};
  end

  logic out_vld_q;

  assign adv         = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vertex_index_o <= d_side.idx;
      ndc_x_o        <= $signed(ndc_x_d);
      ndc_y_o        <= $signed(ndc_y_d);
      tex_s_o        <= d_side.tex_s;
      tex_t_o        <= d_side.tex_t;
      last_o         <= d_side.last;
    end
  end

endmodule

`default_nettype wire

>>> design/sqvt_cordic.sv
// Pipelined CORDIC giving rounded Q2.14 cosine and sine, with corner data alongside.
`default_nettype none

module sqvt_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic [15:0]                        angle_i,
  input  sqvt_pkg::vtx_t                     side_i,
  output logic                               vld_o,
  output logic signed [sqvt_pkg::TRIG_W-1:0] cos_o,
  output logic signed [sqvt_pkg::TRIG_W-1:0] sin_o,
  output sqvt_pkg::vtx_t                     side_o
);
  import sqvt_pkg::*;

  localparam int N = TRIG_STAGES;

  logic [N:0]              vld_q;
  logic signed [XY_W-1:0]  x_q    [N+1];
  logic signed [XY_W-1:0]  y_q    [N+1];
  logic signed [Z_W-1:0]   z_q    [N+1];
  logic [1:0]              quad_q [N+1];
  vtx_t                    side_q [N+1];

  logic [31:0] a_turn;
  logic [31:0] a_bias;
  logic [31:0] a_red;
  logic [1:0]  quad;

  // Reduce the angle to the nearest quadrant
  always_comb begin
    a_turn = {angle_i, 16'b0} & ANGLE_MASK;
    a_bias = a_turn + 32'h2000_0000;
    quad   = a_bias[31:30];
    a_red  = a_turn - {quad, 30'b0};
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-1:0], vld_i};
      vld_o <= vld_q[N];
    end
  end

  // Load stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= Z_W'($signed(a_red));
      quad_q[0] <= quad;
      side_q[0] <= side_i;
    end
  end

  // Micro-rotations, one per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [Z_W-1:0] AT = Z_W'(atan_turn(i));
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][Z_W-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - AT;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + AT;
        end
        quad_q[i+1] <= quad_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // Round half up to Q2.14, then restore the quadrant
  logic signed [XY_W-1:0]   x_rnd;
  logic signed [XY_W-1:0]   y_rnd;
  logic signed [TRIG_W-1:0] c_r;
  logic signed [TRIG_W-1:0] s_r;
  logic signed [TRIG_W-1:0] c_d;
  logic signed [TRIG_W-1:0] s_d;

  always_comb begin
    x_rnd = x_q[N] + XY_W'(32768);
    y_rnd = y_q[N] + XY_W'(32768);
    c_r   = TRIG_W'(x_rnd >>> 16);
    s_r   = TRIG_W'(y_rnd >>> 16);
    case (quad_q[N])
      2'd0: begin
        c_d = c_r;
        s_d = s_r;
      end
      2'd1: begin
        c_d = -s_r;
        s_d = c_r;
      end
      2'd2: begin
        c_d = -c_r;
        s_d = -s_r;
      end
      default: begin
        c_d = s_r;
        s_d = -c_r;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o  <= c_d;
      sin_o  <= s_d;
      side_o <= side_q[N];
    end
  end

endmodule

`default_nettype wire

>>> design/sqvt_div.sv
// Range check and pipelined restoring division of both NDC numerators.
`default_nettype none

module sqvt_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic signed [sqvt_pkg::SUM_W-1:0] num_x_i,
  input  logic signed [sqvt_pkg::SUM_W-1:0] num_y_i,
  input  logic [sqvt_pkg::DEN_W-1:0]        den_x_i,
  input  logic [sqvt_pkg::DEN_W-1:0]        den_y_i,
  input  sqvt_pkg::side_t                   side_i,
  output logic                              vld_o,
  output logic [sqvt_pkg::DIV_Q_W-1:0]      quo_x_o,
  output logic [sqvt_pkg::DIV_Q_W-1:0]      quo_y_o,
  output sqvt_pkg::sat_t                    sat_o,
  output sqvt_pkg::side_t                   side_o
);
  import sqvt_pkg::*;

  localparam int N = DIV_STEPS;

  logic [N:0] vld_q;
  sat_t       sat_q  [N+1];
  side_t      side_q [N+1];

  logic signed [SUM_W-1:0] num [2];
  logic [DEN_W-1:0]        den [2];
  logic                    neg [2];
  logic                    hi  [2];

  assign num[0] = num_x_i;
  assign num[1] = num_y_i;
  assign den[0] = den_x_i;
  assign den[1] = den_y_i;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-1:0], vld_i};
    end
  end

  // Side data and range flags
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0]  <= '{neg_x: neg[0], hi_x: hi[0], neg_y: neg[1], hi_y: hi[1]};
      side_q[0] <= side_i;
      for (int k = 0; k < N; k++) begin
        sat_q[k+1]  <= sat_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic [DEN_W-1:0] rem_q [N+1];
    logic [DIV_Q_W-1:0] sh_q [N+1];

    // Below zero or at 65536 times the divisor the quotient saturates
    assign neg[ax] = num[ax][SUM_W-1];
    assign hi[ax]  = !num[ax][SUM_W-1] &&
                     (num[ax][SUM_W-2:0] >= (SUM_W-1)'({den[ax], {DIV_Q_W{1'b0}}}));

    // In range the upper half is already below the divisor
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0] <= num[ax][2*DIV_Q_W-1:DIV_Q_W];
        sh_q[0]  <= num[ax][DIV_Q_W-1:0];
      end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < N; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           ge;
      logic [DEN_W:0] diff;
      assign trial = {rem_q[k], sh_q[k][DIV_Q_W-1]};
      assign ge    = trial >= {1'b0, den[ax]};
      assign diff  = trial - {1'b0, den[ax]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          sh_q[k+1]  <= {sh_q[k][DIV_Q_W-2:0], ge};
        end
      end
    end
  end

  assign vld_o   = vld_q[N];
  assign quo_x_o = g_axis[0].sh_q[N];
  assign quo_y_o = g_axis[1].sh_q[N];
  assign sat_o   = sat_q[N];
  assign side_o  = side_q[N];

endmodule

`default_nettype wire

>>> design/sqvt_checker.sv
// Port-level checks of the sprite quad vertex transform, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module sqvt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  vertex_index_o,
  input logic [15:0] ndc_x_o,
  input logic [15:0] ndc_y_o,
  input logic [16:0] tex_s_o,
  input logic [16:0] tex_t_o,
  input logic        last_o
);

  // last marks exactly the fourth corner
  `SQ_ASSERT(a_last_idx, clk_i, rst_ni, out_valid_o |-> (last_o == (vertex_index_o == 2'd3)), "last flag does not match corner 3")

  // a taken sprite occupies the sequencer, so no second sprite is taken right behind it
  `SQ_ASSERT(a_one_per_four, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "sprite request taken on consecutive cycles")

  // a stalled vertex is held
  `SQ_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(ndc_x_o) && $stable(ndc_y_o) && $stable(tex_s_o) && $stable(tex_t_o) && $stable(vertex_index_o)), "stalled vertex changed")

  // nothing is offered while reset is held
  `SQ_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "vertex valid during reset")

endmodule

bind sprite_quad_vertex_transform_core sqvt_checker u_sqvt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .vertex_index_o (vertex_index_o),
  .ndc_x_o        (ndc_x_o),
  .ndc_y_o        (ndc_y_o),
  .tex_s_o        (tex_s_o),
  .tex_t_o        (tex_t_o),
  .last_o         (last_o)
);

`default_nettype wire

>>> verif/sprite_quad_vertex_transform_core_tb.sv
// Self-checking testbench for the sprite quad vertex transform core.
`timescale 1ns / 1ps

module sprite_quad_vertex_transform_core_tb;
  import sqvt_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 80;

  // One emitted vertex
  typedef struct {
    logic [1:0]         idx;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic [16:0]        s;
    logic [16:0]        t;
    logic               lst;
  } vertex_t;

  // One sprite request
  typedef struct {
    logic [15:0] px, py, sw, sh, ox, oy, ang, u, v, tw, th;
  } sprite_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sprite_t spr = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] o_idx;
  logic signed [15:0] o_nx, o_ny;
  logic [16:0] o_s, o_t;
  logic o_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
  logic [SCR_W-1:0] cfg_data = '0;

  // Predictor copy of the screen registers
  logic [SCR_W-1:0] scr_w = 13'd1920;
  logic [SCR_W-1:0] scr_h = 13'd1080;

  vertex_t pending_vertices[$];
  int errors = 0;
  int vertices_seen = 0;
  int sprites_sent = 0;
  int cycle = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  sprite_quad_vertex_transform_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pos_x_i(spr.px), .pos_y_i(spr.py),
    .sprite_width_i(spr.sw), .sprite_height_i(spr.sh),
    .origin_x_i(spr.ox), .origin_y_i(spr.oy), .angle_i(spr.ang),
    .tex_u_i(spr.u), .tex_v_i(spr.v), .tex_w_i(spr.tw), .tex_h_i(spr.th),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .vertex_index_o(o_idx), .ndc_x_o(o_nx), .ndc_y_o(o_ny),
    .tex_s_o(o_s), .tex_t_o(o_t), .last_o(o_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Arithmetic shift right that floors
  function automatic longint shr_floor(longint a, int sh);
    return a >>> sh;
  endfunction

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic logic [15:0] clamp16(longint a);
    if (a > 32767) return 16'h7FFF;
    if (a < -32768) return 16'h8000;
    return a[15:0];
  endfunction

  // Cosine and sine of the angle, Q2.14, CORDIC around the nearest quadrant
  task automatic sincos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a, r;
    logic [1:0] q;
    longint x, y, z, dx, dy, tmp;
    a = {ang, 16'h0} & ANGLE_MASK;
    q = 2'((a + 32'h2000_0000) >> 30);
    r = a - ({30'd0, q} << 30);
    z = longint'($signed(r));
    x = 652032874;
    y = 0;
    for (int i = 0; i < TRIG_STAGES && i < 24; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    c = shr_floor(x + 32768, 16);
    s = shr_floor(y + 32768, 16);
    case (q)
      2'd0: ;
      2'd1: begin tmp = c; c = -s; s = tmp; end
      2'd2: begin c = -c; s = -s; end
      default: begin tmp = c; c = s; s = -tmp; end
    endcase
  endtask

  // Four corner vertices of one sprite
  task automatic predict_corners(input sprite_t sp);
    longint c, s, lx, ly, rx, ry, wd, ht;
    vertex_t vx;
    sincos(sp.ang, c, s);
    wd = (scr_w == 0) ? 1 : longint'(scr_w);
    ht = (scr_h == 0) ? 1 : longint'(scr_h);
    for (int k = 0; k < 4; k++) begin
      lx = -longint'($signed(sp.ox)) + ((k & 2) ? longint'(sp.sw) : 0);
      ly = -longint'($signed(sp.oy)) + ((k & 1) ? longint'(sp.sh) : 0);
      rx = lx * c - ly * s + longint'($signed(sp.px)) * 16384;
      ry = lx * s + ly * c + longint'($signed(sp.py)) * 16384;
      vx.idx = 2'(k);
      vx.nx = clamp16(div_floor(rx + 4 * wd, 8 * wd) - 16384);
      vx.ny = clamp16(16384 - div_floor(ry + 4 * ht, 8 * ht));
      vx.s = (k & 2) ? {1'b0, sp.u} + {1'b0, sp.tw} : {1'b0, sp.u};
      vx.t = (k & 1) ? {1'b0, sp.v} + {1'b0, sp.th} : {1'b0, sp.v};
      vx.lst = (k == 3);
      pending_vertices.push_back(vx);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle, what, got, want);
  endtask

  // Vertex checker
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n && out_valid && !out_stall) begin
      vertex_t want;
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected vertex, index", o_idx, -1);
      end else begin
        want = pending_vertices.pop_front();
        if (o_idx !== want.idx) report_mismatch("vertex_index", o_idx, want.idx);
        if (o_nx !== want.nx) report_mismatch("ndc_x", o_nx, want.nx);
        if (o_ny !== want.ny) report_mismatch("ndc_y", o_ny, want.ny);
        if (o_s !== want.s) report_mismatch("tex_s", o_s, want.s);
        if (o_t !== want.t) report_mismatch("tex_t", o_t, want.t);
        if (o_last !== want.lst) report_mismatch("last", o_last, want.lst);
      end
    end
  end

  // Random output stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Valid stays high after the accepting edge; the next idle cycle or the caller drops it
  task automatic send_sprite(input sprite_t sp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    spr <= sp;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_corners(sp);
    sprites_sent++;
  endtask

  // Registers are only written once the pipeline has drained
  task automatic write_screen(input logic [SCR_W-1:0] wd, input logic [SCR_W-1:0] ht);
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= wd;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scr_w = wd;
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= ht;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scr_h = ht;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sprite_t random_sprite();
    sprite_t sp;
    sp.px = 16'($urandom); sp.py = 16'($urandom);
    sp.ox = 16'($urandom); sp.oy = 16'($urandom);
    sp.ang = 16'($urandom);
    sp.u = 16'($urandom); sp.v = 16'($urandom);
    sp.tw = 16'($urandom); sp.th = 16'($urandom);
    // mostly on-screen sizes, sometimes any size
    if ($urandom_range(3) == 0) begin
      sp.sw = 16'($urandom); sp.sh = 16'($urandom);
      sp.px = 16'($urandom_range(32767)); sp.py = 16'($urandom_range(32767));
    end else begin
      sp.sw = 16'($urandom_range(4095)); sp.sh = 16'($urandom_range(4095));
      sp.px = 16'($urandom_range(30000)); sp.py = 16'($urandom_range(17000));
      sp.ox = 16'($signed(16'($urandom_range(2047))) - 16'sd1024);
      sp.oy = 16'($signed(16'($urandom_range(2047))) - 16'sd1024);
    end
    return sp;
  endfunction

  // Directed rows: px py sw sh ox oy ang u v tw th
  sprite_t directed_rows[] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h0000,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000,
      16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF},
    '{16'h3C00, 16'h21C0, 16'h0400, 16'h0200, 16'h0200, 16'h0100, 16'h4000,
      16'h1000, 16'h2000, 16'h4000, 16'h8000},
    '{16'h3C00, 16'h21C0, 16'h0400, 16'h0200, 16'h0200, 16'h0100, 16'hC000,
      16'h1234, 16'h5678, 16'h0F0F, 16'hF0F0},
    '{16'h1000, 16'h1000, 16'h0800, 16'h0800, 16'h0000, 16'h0000, 16'h2000,
      16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA},
    '{16'h1000, 16'h1000, 16'h0800, 16'h0800, 16'h0400, 16'h0400, 16'h6000,
      16'h0001, 16'h0001, 16'h0001, 16'h0001},
    '{16'h1000, 16'h1000, 16'h0800, 16'h0800, 16'hFC00, 16'hFC00, 16'hE000,
      16'h8000, 16'h8000, 16'h8000, 16'h8000},
    '{16'h0000, 16'h0000, 16'h0010, 16'h0010, 16'h0000, 16'h0000, 16'hFFFF,
      16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001,
      16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}
  };

  // Screen settings per phase, extremes among them, zero acting as one
  logic [SCR_W-1:0] phase_w[] = '{13'd1920, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd640};
  logic [SCR_W-1:0] phase_h[] = '{13'd1080, 13'd4096, 13'd1, 13'd8191, 13'd0, 13'd480};

  initial begin
    int idle_mode;
    sprite_t sp;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rows after reset: one row typed in, reset screen 1920x1080, origin zero
    sp = directed_rows[0];
    send_sprite(sp);
    begin
      // corner 0 at pixel 0: ndc -1 and +1
      vertex_t first;
      first = pending_vertices[0];
      if (first.nx != 16'shC000 || first.ny != 16'sh4000)
        report_mismatch("predictor at origin", first.nx, -16384);
    end
    foreach (directed_rows[i]) if (i > 0) send_sprite(directed_rows[i]);

    for (int ph = 0; ph < phase_w.size(); ph++) begin
      write_screen(phase_w[ph], phase_h[ph]);
      for (int j = 0; j < 3; j++) send_sprite(directed_rows[$urandom_range(9)]);
      for (int j = 0; j < 12; j++) begin
        idle_mode = (j / 3) % 4;
        send_idle_pct = (idle_mode == 1 || idle_mode == 3) ? ((idle_mode == 3) ? 37 : 62) : 0;
        stall_pct = (idle_mode == 2 || idle_mode == 3) ? ((idle_mode == 3) ? 37 : 62) : 0;
        send_sprite(random_sprite());
      end
      send_idle_pct = 0;
      stall_pct = 0;
    end

    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d sprites over %0d screen settings, checked %0d vertices.",
             sprites_sent, phase_w.size() + 1, vertices_seen);
    $display("Idle and stall mixes covered, %0d mismatches.", errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit
  always @(posedge clk) begin
    if (cycle > LIMIT_CYCLES) begin
      $display("Run limit reached with %0d vertices outstanding.", pending_vertices.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
